### rtl/complex_arithmetic_unit_macros.svh
// Assertion macros for the complex arithmetic unit.
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CAU_ASSERT_IMPL(label, clk_s, rst_s, lhs, rhs, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (lhs) |-> (rhs)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define CAU_ASSERT_NEXT(label, clk_s, rst_s, lhs, rhs, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (lhs) |=> (rhs)) \
        else $error(msg);
`endif

### rtl/cau_pkg.sv
// Package of shared types and constants for the complex arithmetic unit.
package cau_pkg;
    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    // Control that travels with an item along the divider row.
    typedef struct packed {
        logic       valid;
        logic       is_div;
        logic       dz;
        logic       neg_re;
        logic       neg_im;
    } cau_ctl_t;
endpackage

### rtl/cau_front.sv
// Front stages: products, sums and signs for every operation.
module cau_front #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF,
    localparam int PW = 2 * DATA_WIDTH + 2,
    localparam int MW = PW + FRAC_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [1:0]                   op,
    input  logic signed [DATA_WIDTH-1:0] ar,
    input  logic signed [DATA_WIDTH-1:0] ai,
    input  logic signed [DATA_WIDTH-1:0] br,
    input  logic signed [DATA_WIDTH-1:0] bi,
    output cau_pkg::cau_ctl_t            ctl,
    output logic [MW-1:0]                mag_re,
    output logic [MW-1:0]                mag_im,
    output logic [PW-1:0]                den,
    output logic signed [PW-1:0]         val_re,
    output logic signed [PW-1:0]         val_im
);
    localparam int DW = 2 * DATA_WIDTH;
    // Stage 1: six products and the sums or differences.
    logic signed [DW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [DW-1:0] s_rr_reg, s_ii_reg;
    logic signed [DATA_WIDTH:0] sum_re_reg, sum_im_reg;
    logic [1:0] op_reg;
    logic       v1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg   <= op;
            p_rr_reg <= DW'(ar * br);
            p_ii_reg <= DW'(ai * bi);
            p_ri_reg <= DW'(ar * bi);
            p_ir_reg <= DW'(ai * br);
            s_rr_reg <= DW'(br * br);
            s_ii_reg <= DW'(bi * bi);
            if (op == cau_pkg::OP_SUB)
            begin
                sum_re_reg <= (DATA_WIDTH+1)'(ar) - (DATA_WIDTH+1)'(br);
                sum_im_reg <= (DATA_WIDTH+1)'(ai) - (DATA_WIDTH+1)'(bi);
            end
            else
            begin
                sum_re_reg <= (DATA_WIDTH+1)'(ar) + (DATA_WIDTH+1)'(br);
                sum_im_reg <= (DATA_WIDTH+1)'(ai) + (DATA_WIDTH+1)'(bi);
            end
        end
    end

    // Stage 2: combine products, take magnitudes.
    logic signed [PW-1:0] nre, nim, mre, mim;
    logic [PW-1:0]        dsum;
    always_comb
    begin
        nre  = PW'(p_rr_reg) + PW'(p_ii_reg);
        nim  = PW'(p_ir_reg) - PW'(p_ri_reg);
        mre  = PW'(p_rr_reg) - PW'(p_ii_reg);
        mim  = PW'(p_ri_reg) + PW'(p_ir_reg);
        dsum = PW'($unsigned(s_rr_reg)) + PW'($unsigned(s_ii_reg));
    end

    cau_pkg::cau_ctl_t ctl_reg;
    logic [MW-1:0] mag_re_reg, mag_im_reg;
    logic [PW-1:0] den_reg;
    logic signed [PW-1:0] val_re_reg, val_im_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg.valid  <= v1_reg;
            ctl_reg.is_div <= (op_reg == cau_pkg::OP_DIV);
            ctl_reg.dz     <= (dsum == '0);
            ctl_reg.neg_re <= nre[PW-1];
            ctl_reg.neg_im <= nim[PW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_re_reg <= MW'($unsigned(nre[PW-1] ? -nre : nre)) << FRAC_BITS;
            mag_im_reg <= MW'($unsigned(nim[PW-1] ? -nim : nim)) << FRAC_BITS;
            den_reg    <= dsum;
            unique case (op_reg)
                cau_pkg::OP_ADD, cau_pkg::OP_SUB:
                begin
                    val_re_reg <= PW'(sum_re_reg);
                    val_im_reg <= PW'(sum_im_reg);
                end
                default:
                begin
                    val_re_reg <= mre >>> FRAC_BITS;
                    val_im_reg <= mim >>> FRAC_BITS;
                end
            endcase
        end
    end

    assign ctl    = ctl_reg;
    assign mag_re = mag_re_reg;
    assign mag_im = mag_im_reg;
    assign den    = den_reg;
    assign val_re = val_re_reg;
    assign val_im = val_im_reg;
endmodule

### rtl/cau_div_cell.sv
// One restoring division cell: one quotient bit for both parts per cycle while en is high.
module cau_div_cell #(
    parameter int MW = 42,
    parameter int PW = 34,
    parameter int BIT = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  cau_pkg::cau_ctl_t    ctl_in,
    input  logic [MW-1:0]        rem_re_in,
    input  logic [MW-1:0]        rem_im_in,
    input  logic [MW-1:0]        q_re_in,
    input  logic [MW-1:0]        q_im_in,
    input  logic [PW-1:0]        den_in,
    input  logic signed [PW-1:0] val_re_in,
    input  logic signed [PW-1:0] val_im_in,
    output cau_pkg::cau_ctl_t    ctl_out,
    output logic [MW-1:0]        rem_re_out,
    output logic [MW-1:0]        rem_im_out,
    output logic [MW-1:0]        q_re_out,
    output logic [MW-1:0]        q_im_out,
    output logic [PW-1:0]        den_out,
    output logic signed [PW-1:0] val_re_out,
    output logic signed [PW-1:0] val_im_out
);
    localparam int EW = MW + PW;
    logic [EW-1:0] sh_den, r_re, r_im;
    logic          ge_re, ge_im;
    always_comb
    begin
        sh_den = EW'(den_in) << BIT;
        r_re   = EW'(rem_re_in);
        r_im   = EW'(rem_im_in);
        ge_re  = r_re >= sh_den;
        ge_im  = r_im >= sh_den;
    end

    cau_pkg::cau_ctl_t ctl_reg;
    logic [MW-1:0] rem_re_reg, rem_im_reg, q_re_reg, q_im_reg;
    logic [PW-1:0] den_reg;
    logic signed [PW-1:0] val_re_reg, val_im_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_re_reg <= ge_re ? MW'(r_re - sh_den) : rem_re_in;
            rem_im_reg <= ge_im ? MW'(r_im - sh_den) : rem_im_in;
            q_re_reg   <= q_re_in | (MW'(ge_re) << BIT);
            q_im_reg   <= q_im_in | (MW'(ge_im) << BIT);
            den_reg    <= den_in;
            val_re_reg <= val_re_in;
            val_im_reg <= val_im_in;
        end
    end

    assign ctl_out    = ctl_reg;
    assign rem_re_out = rem_re_reg;
    assign rem_im_out = rem_im_reg;
    assign q_re_out   = q_re_reg;
    assign q_im_out   = q_im_reg;
    assign den_out    = den_reg;
    assign val_re_out = val_re_reg;
    assign val_im_out = val_im_reg;
endmodule

### rtl/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: front stages, divider row, output.
//
//  channel | dir | fields (low bit up)
//  s_axis  | in  | tdata: a_re, a_im, b_re, b_im ; tuser: operation
//  m_axis  | out | tdata: res_re, res_im ; tuser: status
//
// One item per cycle while m_axis is not stalled; the path is 2 front
// stages, one cell per quotient bit (2*DATA_WIDTH+2+FRAC_BITS cells, 42
// by default) and one output register. The cell row sets the latency.
// Reset clears all valid flags; payload registers are not reset.
// A stall on m_axis freezes the whole pipeline; s_axis_tready falls
// only while the output register holds an item that is not taken.
`include "complex_arithmetic_unit_macros.svh"
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF,
    localparam int DB = ((4 * DATA_WIDTH) + 7) / 8 * 8,
    localparam int OB = ((2 * DATA_WIDTH) + 7) / 8 * 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [DB-1:0] s_axis_tdata,  // a_re, a_im, b_re, b_im
    input  logic [7:0]    s_axis_tuser,  // operation
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [OB-1:0] m_axis_tdata,  // res_re, res_im
    output logic [7:0]    m_axis_tuser   // status
);
    localparam int PW = 2 * DATA_WIDTH + 2;
    localparam int MW = PW + FRAC_BITS;
    localparam int NC = MW;
    localparam logic signed [PW-1:0] DMAX = PW'((64'sd1 <<< (DATA_WIDTH - 1)) - 1);
    localparam logic signed [PW-1:0] DMIN = -DMAX - PW'(1);

    // Advance the pipeline whenever the output slot is free or being emptied.
    logic en;
    logic out_valid_reg;
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    cau_pkg::cau_ctl_t    ctl   [NC+1];
    logic [MW-1:0]        rem_re[NC+1], rem_im[NC+1], q_re[NC+1], q_im[NC+1];
    logic [PW-1:0]        den   [NC+1];
    logic signed [PW-1:0] vre   [NC+1], vim[NC+1];

    cau_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s_axis_tvalid),
        .op(s_axis_tuser[1:0]),
        .ar(s_axis_tdata[DATA_WIDTH-1:0]),
        .ai(s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .br(s_axis_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH]),
        .bi(s_axis_tdata[4*DATA_WIDTH-1:3*DATA_WIDTH]),
        .ctl(ctl[0]), .mag_re(rem_re[0]), .mag_im(rem_im[0]),
        .den(den[0]), .val_re(vre[0]), .val_im(vim[0])
    );
    assign q_re[0] = '0;
    assign q_im[0] = '0;

    // Row of cells, most significant quotient bit first.
    for (genvar g = 0; g < NC; g++)
    begin : g_cell
        cau_div_cell #(.MW(MW), .PW(PW), .BIT(NC - 1 - g)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .ctl_in(ctl[g]), .rem_re_in(rem_re[g]), .rem_im_in(rem_im[g]),
            .q_re_in(q_re[g]), .q_im_in(q_im[g]), .den_in(den[g]),
            .val_re_in(vre[g]), .val_im_in(vim[g]),
            .ctl_out(ctl[g+1]), .rem_re_out(rem_re[g+1]), .rem_im_out(rem_im[g+1]),
            .q_re_out(q_re[g+1]), .q_im_out(q_im[g+1]), .den_out(den[g+1]),
            .val_re_out(vre[g+1]), .val_im_out(vim[g+1])
        );
    end

    // Final sign, saturation and status selection.
    cau_pkg::cau_ctl_t    cl;
    logic signed [MW:0]   sre, sim;
    logic signed [DATA_WIDTH-1:0] ore, oim;
    logic sat_re, sat_im;
    logic [1:0] st;
    always_comb
    begin
        cl  = ctl[NC];
        sre = cl.is_div ? (cl.neg_re ? -$signed({1'b0, q_re[NC]}) : $signed({1'b0, q_re[NC]}))
                        : (MW+1)'(vre[NC]);
        sim = cl.is_div ? (cl.neg_im ? -$signed({1'b0, q_im[NC]}) : $signed({1'b0, q_im[NC]}))
                        : (MW+1)'(vim[NC]);
        sat_re = (sre > (MW+1)'(DMAX)) || (sre < (MW+1)'(DMIN));
        sat_im = (sim > (MW+1)'(DMAX)) || (sim < (MW+1)'(DMIN));
        ore = sat_re ? (sre[MW] ? DATA_WIDTH'(DMIN) : DATA_WIDTH'(DMAX)) : DATA_WIDTH'(sre);
        oim = sat_im ? (sim[MW] ? DATA_WIDTH'(DMIN) : DATA_WIDTH'(DMAX)) : DATA_WIDTH'(sim);
        st  = (sat_re || sat_im) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        if (cl.is_div && cl.dz)
        begin
            ore = '0;
            oim = '0;
            st  = cau_pkg::ST_DZ;
        end
    end

    logic [DATA_WIDTH-1:0] res_re_reg, res_im_reg;
    logic [1:0]            status_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= cl.valid;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_re_reg <= ore;
            res_im_reg <= oim;
            status_reg <= st;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OB'({res_im_reg, res_re_reg});
    assign m_axis_tuser  = {6'd0, status_reg};

    `CAU_ASSERT_IMPL(a_ready_free, clk, rst_n, !out_valid_reg, s_axis_tready, "ready low with empty output")
    `CAU_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output item dropped under stall")
    `CAU_ASSERT_IMPL(a_dz, clk, rst_n, m_axis_tvalid && (m_axis_tuser[1:0] == cau_pkg::ST_DZ), m_axis_tdata == '0, "divide by zero with nonzero result")
endmodule
